>>> rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants of the planar texture coordinate block.
// ----------------------------------------------------------------------------
package ptc_pkg;

   localparam int COORD_W   = 32;
   localparam int NRM_W     = 16;
   localparam int DIM_REG_W = 13;
   localparam int IDX_W     = 12;
   localparam int UNIT_W    = 16;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int UNIT_FRAC = 14;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_H    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_W    = 3'd7;

   typedef struct packed {
      logic signed [UNIT_W-1:0] x;
      logic signed [UNIT_W-1:0] y;
      logic signed [UNIT_W-1:0] z;
   } unit_vec_type;

   typedef struct packed {
      unit_vec_type u1;
      unit_vec_type u2;
      logic         degenerate;
   } axes_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] x;
      logic signed [DIFF_W-1:0] y;
      logic signed [DIFF_W-1:0] z;
   } diff_type;

endpackage

>>> rtl/ptc_if.sv
// ----------------------------------------------------------------------------
// ptc_if
// Request and response channel interfaces, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink (input valid, input point_x, input point_y, input point_z,
                 output ready);
endinterface

interface ptc_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] tex_row;
   logic [11:0] tex_col;
   logic        degenerate;
   modport source (output valid, output tex_row, output tex_col, output degenerate,
                   input ready);
   modport sink (input valid, input tex_row, input tex_col, input degenerate,
                 output ready);
endinterface

>>> rtl/ptc_axes.sv
// ----------------------------------------------------------------------------
// ptc_axes
// Sequencer that derives the two unit in-plane axes from the plane normal.
// ----------------------------------------------------------------------------
module ptc_axes (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [15:0]        normal_x,
   input  logic signed [15:0]        normal_y,
   input  logic signed [15:0]        normal_z,
   output logic                      busy,
   output ptc_pkg::axes_type         axes
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SUM, ST_TGT, ST_SQ, ST_CMP, ST_NEXT, ST_CROSS
   } state_type;

   state_type          state_ff;
   logic [1:0]         phase_ff;
   logic [1:0]         comp_ff;
   logic [3:0]         bit_ff;
   logic [2:0]         step_ff;
   logic [15:0]        q_ff;
   logic [31:0]        s_ff;
   logic [59:0]        tgt_ff;
   logic [31:0]        cc_ff;
   logic signed [31:0] acc_ff;
   logic signed [16:0] vec_ff [3];
   logic signed [16:0] res_ff [3];
   logic signed [15:0] un_ff [3];
   logic signed [15:0] u1_ff [3];
   logic signed [15:0] u2_ff [3];
   logic               deg_ff;

   logic signed [16:0] cur;
   logic [15:0]        cur_mag;
   logic [31:0]        cur_sq;
   logic [15:0]        cand;
   logic [31:0]        cand_sq;
   logic [63:0]        big;
   logic               fits;
   logic [15:0]        q_new;
   logic signed [16:0] res_val;
   logic [1:0]         k;
   logic [1:0]         ia;
   logic [1:0]         ib;
   logic [1:0]         k1;
   logic [1:0]         k2;
   logic signed [31:0] prod;
   logic signed [32:0] diff;
   logic [32:0]        dmag;
   logic [32:0]        dsh;
   logic signed [16:0] cval;
   logic [15:0]        m0;
   logic [15:0]        m1;
   logic [15:0]        m2;
   logic [1:0]         msel;
   logic               nzero;

   always_comb begin
      cur     = vec_ff[comp_ff];
      cur_mag = cur[16] ? 16'(-cur) : 16'(cur);
      cur_sq  = cur_mag * cur_mag;
      cand    = q_ff | (16'd1 << bit_ff);
      cand_sq = cand * cand;
      big     = 64'(cc_ff) * 64'(s_ff);
      fits    = (s_ff != 32'd0) && (big <= 64'(tgt_ff));
      q_new   = fits ? cand : q_ff;
      res_val = cur[16] ? -$signed({1'b0, q_new}) : $signed({1'b0, q_new});
      k = step_ff[2:1];
      unique case (k)
         2'd0: begin k1 = 2'd1; k2 = 2'd2; end
         2'd1: begin k1 = 2'd2; k2 = 2'd0; end
         2'd2: begin k1 = 2'd0; k2 = 2'd1; end
         default: begin k1 = 2'd0; k2 = 2'd0; end
      endcase
      ia   = step_ff[0] ? k2 : k1;
      ib   = step_ff[0] ? k1 : k2;
      prod = u1_ff[ia] * un_ff[ib];
      diff = 33'(acc_ff) - 33'(prod);
      dmag = diff[32] ? 33'(-diff) : 33'(diff);
      dsh  = dmag >> ptc_pkg::UNIT_FRAC;
      cval = diff[32] ? -$signed(17'(dsh)) : $signed(17'(dsh));
      m0 = res_ff[0][16] ? 16'(-res_ff[0]) : 16'(res_ff[0]);
      m1 = res_ff[1][16] ? 16'(-res_ff[1]) : 16'(res_ff[1]);
      m2 = res_ff[2][16] ? 16'(-res_ff[2]) : 16'(res_ff[2]);
      if (m0 > m1) begin
         msel = (m1 > m2) ? 2'd2 : 2'd1;
      end else begin
         msel = (m0 > m2) ? 2'd2 : 2'd0;
      end
      nzero = (normal_x == 16'sd0) && (normal_y == 16'sd0) && (normal_z == 16'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         deg_ff   <= 1'b0;
      end else if (start) begin
         vec_ff[0] <= 17'(normal_x);
         vec_ff[1] <= 17'(normal_y);
         vec_ff[2] <= 17'(normal_z);
         phase_ff  <= 2'd0;
         comp_ff   <= 2'd0;
         s_ff      <= 32'd0;
         deg_ff    <= nzero;
         state_ff  <= nzero ? ST_IDLE : ST_SUM;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
            end
            ST_SUM: begin
               s_ff <= s_ff + cur_sq;
               if (comp_ff == 2'd2) begin
                  comp_ff  <= 2'd0;
                  state_ff <= ST_TGT;
               end else begin
                  comp_ff <= comp_ff + 2'd1;
               end
            end
            ST_TGT: begin
               tgt_ff   <= {cur_sq, 28'd0};
               q_ff     <= 16'd0;
               bit_ff   <= 4'd15;
               state_ff <= ST_SQ;
            end
            ST_SQ: begin
               cc_ff    <= cand_sq;
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               q_ff <= q_new;
               if (bit_ff == 4'd0) begin
                  res_ff[comp_ff] <= res_val;
                  if (comp_ff == 2'd2) begin
                     state_ff <= ST_NEXT;
                  end else begin
                     comp_ff  <= comp_ff + 2'd1;
                     state_ff <= ST_TGT;
                  end
               end else begin
                  bit_ff   <= bit_ff - 4'd1;
                  state_ff <= ST_SQ;
               end
            end
            ST_NEXT: begin
               comp_ff <= 2'd0;
               s_ff    <= 32'd0;
               unique case (phase_ff)
                  2'd0: begin
                     for (int i = 0; i < 3; i++) un_ff[i] <= 16'(res_ff[i]);
                     unique case (msel)
                        2'd0: begin
                           vec_ff[0] <= 17'sd0;
                           vec_ff[1] <= res_ff[2];
                           vec_ff[2] <= -res_ff[1];
                        end
                        2'd1: begin
                           vec_ff[0] <= res_ff[2];
                           vec_ff[1] <= 17'sd0;
                           vec_ff[2] <= -res_ff[0];
                        end
                        default: begin
                           vec_ff[0] <= res_ff[1];
                           vec_ff[1] <= -res_ff[0];
                           vec_ff[2] <= 17'sd0;
                        end
                     endcase
                     phase_ff <= 2'd1;
                     state_ff <= ST_SUM;
                  end
                  2'd1: begin
                     for (int i = 0; i < 3; i++) u1_ff[i] <= 16'(res_ff[i]);
                     step_ff  <= 3'd0;
                     state_ff <= ST_CROSS;
                  end
                  default: begin
                     for (int i = 0; i < 3; i++) u2_ff[i] <= 16'(res_ff[i]);
                     state_ff <= ST_IDLE;
                  end
               endcase
            end
            ST_CROSS: begin
               if (!step_ff[0]) begin
                  acc_ff <= prod;
               end else begin
                  vec_ff[k] <= cval;
               end
               if (step_ff == 3'd5) begin
                  phase_ff <= 2'd2;
                  comp_ff  <= 2'd0;
                  s_ff     <= 32'd0;
                  state_ff <= ST_SUM;
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign axes.u1 = '{x: u1_ff[0], y: u1_ff[1], z: u1_ff[2]};
   assign axes.u2 = '{x: u2_ff[0], y: u2_ff[1], z: u2_ff[2]};
   assign axes.degenerate = deg_ff;

endmodule

>>> rtl/ptc_front.sv
// ----------------------------------------------------------------------------
// ptc_front
// Accepts hit points and forms the offset from the plane point.
// ----------------------------------------------------------------------------
module ptc_front (
   input  logic                 clock,
   input  logic                 reset,
   ptc_req_if.sink              req,
   input  logic signed [31:0]   plane_x,
   input  logic signed [31:0]   plane_y,
   input  logic signed [31:0]   plane_z,
   input  logic                 hold,
   input  logic                 q_full,
   output logic                 push,
   output ptc_pkg::diff_type    push_data
);

   logic              v_ff;
   ptc_pkg::diff_type d_ff;
   logic              free;

   assign push      = v_ff && !q_full;
   assign free      = !v_ff || !q_full;
   assign req.ready = free && !hold;
   assign push_data = d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (free) begin
         v_ff <= req.valid && req.ready;
      end
      if (free) begin
         d_ff.x <= 33'(req.point_x) - 33'(plane_x);
         d_ff.y <= 33'(req.point_y) - 33'(plane_y);
         d_ff.z <= 33'(req.point_z) - 33'(plane_z);
      end
   end

endmodule

>>> rtl/ptc_queue.sv
// ----------------------------------------------------------------------------
// ptc_queue
// Four-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module ptc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ptc_pkg::diff_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              nonempty,
   output ptc_pkg::diff_type pop_data
);

   ptc_pkg::diff_type mem_ff [4];
   logic [1:0]        wp_ff;
   logic [1:0]        rp_ff;
   logic [2:0]        cnt_ff;

   assign full     = (cnt_ff == 3'd4);
   assign nonempty = (cnt_ff != 3'd0);
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 2'd0;
         rp_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end

endmodule

>>> rtl/ptc_back.sv
// ----------------------------------------------------------------------------
// ptc_back
// Projects offsets onto the axes and reduces them by the texture size.
// ----------------------------------------------------------------------------
module ptc_back #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int TEX_DIM_MAX     = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_nonempty,
   input  ptc_pkg::diff_type q_data,
   output logic              pop,
   input  ptc_pkg::axes_type axes,
   input  logic [12:0]       tex_height,
   input  logic [12:0]       tex_width,
   ptc_rsp_if.source         rsp
);

   localparam int SH = COORD_FRAC_BITS + ptc_pkg::UNIT_FRAC;
   localparam int PW = ptc_pkg::DIFF_W + ptc_pkg::UNIT_W;
   localparam int SW = PW + 2;
   localparam int IW = SW - SH;
   localparam int DW = $clog2(TEX_DIM_MAX + 1);

   function automatic logic [DW+IW-1:0] rem_step(logic [DW-1:0] rem, logic [IW-1:0] val,
                                                 logic [DW-1:0] dim);
      logic [DW:0] r;
      r = {rem, val[IW-1]};
      if (r >= {1'b0, dim}) r = r - {1'b0, dim};
      return {DW'(r), val << 1};
   endfunction

   logic en;
   logic pv_ff;
   logic signed [PW-1:0] p1_ff [3];
   logic signed [PW-1:0] p2_ff [3];
   logic iv_ff;
   logic [IW-1:0] ir_ff;
   logic [IW-1:0] ic_ff;
   logic rv_ff [IW];
   logic [DW-1:0] rrem_ff [IW];
   logic [IW-1:0] rval_ff [IW];
   logic [DW-1:0] crem_ff [IW];
   logic [IW-1:0] cval_ff [IW];
   logic ov_ff;
   logic [11:0] row_ff;
   logic [11:0] col_ff;
   logic deg_ff;
   logic signed [SW-1:0] s1;
   logic signed [SW-1:0] s2;
   logic [SW-1:0] mg1;
   logic [SW-1:0] mg2;
   logic [DW-1:0] dim_h;
   logic [DW-1:0] dim_w;
   logic [31:0] wide_h;
   logic [31:0] wide_w;

   assign en  = !ov_ff || rsp.ready;
   assign pop = en && q_nonempty;

   always_comb begin
      s1 = SW'(p1_ff[0]) + SW'(p1_ff[1]) + SW'(p1_ff[2]);
      s2 = SW'(p2_ff[0]) + SW'(p2_ff[1]) + SW'(p2_ff[2]);
      mg1 = s1[SW-1] ? SW'(-s1) : SW'(s1);
      mg2 = s2[SW-1] ? SW'(-s2) : SW'(s2);
      dim_h = (32'(tex_height) > 32'(TEX_DIM_MAX)) ? DW'(TEX_DIM_MAX) : DW'(tex_height);
      dim_w = (32'(tex_width) > 32'(TEX_DIM_MAX)) ? DW'(TEX_DIM_MAX) : DW'(tex_width);
      wide_h = 32'(rrem_ff[IW-1]);
      wide_w = 32'(crem_ff[IW-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         iv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= pop;
         iv_ff <= pv_ff;
         ov_ff <= rv_ff[IW-1];
      end
      if (en) begin
         p1_ff[0] <= q_data.x * axes.u1.x;
         p1_ff[1] <= q_data.y * axes.u1.y;
         p1_ff[2] <= q_data.z * axes.u1.z;
         p2_ff[0] <= q_data.x * axes.u2.x;
         p2_ff[1] <= q_data.y * axes.u2.y;
         p2_ff[2] <= q_data.z * axes.u2.z;
         ir_ff <= IW'(mg1 >> SH);
         ic_ff <= IW'(mg2 >> SH);
         deg_ff <= axes.degenerate;
         row_ff <= (axes.degenerate || dim_h == '0) ? 12'd0 : wide_h[11:0];
         col_ff <= (axes.degenerate || dim_w == '0) ? 12'd0 : wide_w[11:0];
      end
   end

   for (genvar k = 0; k < IW; k++) begin : g_rem
      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[k] <= 1'b0;
         end else if (en) begin
            if (k == 0) rv_ff[k] <= iv_ff;
            else rv_ff[k] <= rv_ff[(k == 0) ? 0 : k - 1];
         end
         if (en) begin
            if (k == 0) begin
               {rrem_ff[k], rval_ff[k]} <= rem_step('0, ir_ff, dim_h);
               {crem_ff[k], cval_ff[k]} <= rem_step('0, ic_ff, dim_w);
            end else begin
               {rrem_ff[k], rval_ff[k]} <= rem_step(rrem_ff[(k == 0) ? 0 : k - 1],
                                                     rval_ff[(k == 0) ? 0 : k - 1], dim_h);
               {crem_ff[k], cval_ff[k]} <= rem_step(crem_ff[(k == 0) ? 0 : k - 1],
                                                     cval_ff[(k == 0) ? 0 : k - 1], dim_w);
            end
         end
      end
   end

   assign rsp.valid      = ov_ff;
   assign rsp.tex_row    = row_ff;
   assign rsp.tex_col    = col_ff;
   assign rsp.degenerate = deg_ff;

endmodule

>>> rtl/plane_texture_coordinates_top.sv
// ----------------------------------------------------------------------------
// plane_texture_coordinates_top
// Planar texture mapping: hit point to texture row and column.
//
//  channel  | direction | payload
//  req_ch   | in        | point_x, point_y, point_z (Q16.16)
//  rsp_ch   | out       | tex_row, tex_col, degenerate
//  csr_*    | in        | register index and write data, no read-back
//
// One transaction per cycle while rsp_ch is ready and the axis sequencer is
// idle; the back part reduces indices in a bit-per-stage remainder pipeline.
// After reset and after each normal write the axis sequencer runs, trying one
// candidate bit at a time (shared squarer and multiplier);
// req_ch.ready is low meanwhile.
// A stalled rsp_ch holds the back pipeline; the four-entry queue keeps the
// front accepting until the queue is full.
// ----------------------------------------------------------------------------
module plane_texture_coordinates_top #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int TEX_DIM_MAX     = 4096
) (
   input  logic        clock,
   input  logic        reset,
   ptc_req_if.sink     req_ch,
   ptc_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic signed [31:0] plane_x_ff;
   logic signed [31:0] plane_y_ff;
   logic signed [31:0] plane_z_ff;
   logic signed [15:0] normal_x_ff;
   logic signed [15:0] normal_y_ff;
   logic signed [15:0] normal_z_ff;
   logic [12:0]        tex_h_ff;
   logic [12:0]        tex_w_ff;
   logic               start_ff;
   logic               axes_busy;
   logic               hold;
   ptc_pkg::axes_type  axes;
   logic               q_full;
   logic               q_nonempty;
   logic               push;
   logic               pop;
   ptc_pkg::diff_type  push_data;
   ptc_pkg::diff_type  pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_x_ff  <= '0;
         plane_y_ff  <= '0;
         plane_z_ff  <= '0;
         normal_x_ff <= '0;
         normal_y_ff <= 16'sd16384;
         normal_z_ff <= '0;
         tex_h_ff    <= 13'd256;
         tex_w_ff    <= 13'd256;
         start_ff    <= 1'b1;
      end else begin
         start_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               ptc_pkg::CSR_PLANE_X: plane_x_ff <= csr_wdata;
               ptc_pkg::CSR_PLANE_Y: plane_y_ff <= csr_wdata;
               ptc_pkg::CSR_PLANE_Z: plane_z_ff <= csr_wdata;
               ptc_pkg::CSR_NORMAL_X: begin
                  normal_x_ff <= csr_wdata[15:0];
                  start_ff    <= 1'b1;
               end
               ptc_pkg::CSR_NORMAL_Y: begin
                  normal_y_ff <= csr_wdata[15:0];
                  start_ff    <= 1'b1;
               end
               ptc_pkg::CSR_NORMAL_Z: begin
                  normal_z_ff <= csr_wdata[15:0];
                  start_ff    <= 1'b1;
               end
               ptc_pkg::CSR_TEX_H: tex_h_ff <= csr_wdata[12:0];
               ptc_pkg::CSR_TEX_W: tex_w_ff <= csr_wdata[12:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign hold = axes_busy || start_ff;

   ptc_axes u_axes (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .normal_x (normal_x_ff),
      .normal_y (normal_y_ff),
      .normal_z (normal_z_ff),
      .busy     (axes_busy),
      .axes     (axes)
   );

   ptc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .plane_x   (plane_x_ff),
      .plane_y   (plane_y_ff),
      .plane_z   (plane_z_ff),
      .hold      (hold),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   ptc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .nonempty  (q_nonempty),
      .pop_data  (pop_data)
   );

   ptc_back #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .TEX_DIM_MAX     (TEX_DIM_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_nonempty (q_nonempty),
      .q_data     (pop_data),
      .pop        (pop),
      .axes       (axes),
      .tex_height (tex_h_ff),
      .tex_width  (tex_w_ff),
      .rsp        (rsp_ch)
   );

`ifndef SYNTHESIS
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !axes_busy)
      else $error("request taken during axis setup");

   a_normal_write_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == ptc_pkg::CSR_NORMAL_X || csr_index == ptc_pkg::CSR_NORMAL_Y ||
                 csr_index == ptc_pkg::CSR_NORMAL_Z) |=> !req_ch.ready)
      else $error("ready high right after a normal write");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.degenerate |-> rsp_ch.tex_row == 12'd0 &&
                                            rsp_ch.tex_col == 12'd0)
      else $error("degenerate response with nonzero indices");
`endif

endmodule
